// File: rtl/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

   localparam int COEFF_FRAC_BITS = 20;
   localparam int POSE_FRAC_BITS  = 16;
   localparam int TRIG_ITERATIONS = 16;
   localparam int ANG_FRAC        = 24;
   localparam int TRIG_Q          = 30;
   localparam int MUL_SHIFT       = COEFF_FRAC_BITS + 1 + TRIG_Q - POSE_FRAC_BITS;
   localparam int MOD_STEPS       = 24;

   localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
   localparam logic [24:0]        FULL_TURN    = 25'(64'd360 << POSE_FRAC_BITS);
   localparam logic signed [34:0] HALF_TURN    = 35'(64'd180 << ANG_FRAC);
   localparam logic signed [34:0] QUARTER_TURN = 35'(64'd90 << ANG_FRAC);

   localparam logic [2:0] REG_ENABLE      = 3'd0;
   localparam logic [2:0] REG_LEFT_DIST   = 3'd1;
   localparam logic [2:0] REG_RIGHT_DIST  = 3'd2;
   localparam logic [2:0] REG_LEFT_ANGLE  = 3'd3;
   localparam logic [2:0] REG_RIGHT_ANGLE = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [29:0] ATAN_Q24 [0:23] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
      30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
      30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
      30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229, 30'd115
   };

   typedef struct packed {
      logic               op;
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic signed [47:0] heading;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DELTA, S_MOD, S_WRAP, S_FOLD1, S_FOLD2,
      S_CORDIC, S_TRIG_FIX, S_POSE, S_DONE
   } state_type;

endpackage

// File: rtl/differential_drive_odometry_core.sv
`timescale 1ns / 1ps

// Dead reckoning core for a two-wheel robot.
// The req channel carries one beat per item: op selects an encoder sample
// or a clear of the stored counts and pose. A clear, a sample while the
// block is disabled, and a sample whose counts match the stored ones are
// taken without leaving idle and give no result.
// A sample that moves the robot gives one rsp beat with the new pose after
// these steps in order: delta products, heading reduction modulo 360
// degrees (two bits a cycle), wrapping and folding, CORDIC rotations, a
// split of cosine and sine into sign and magnitude, pose products and the
// load of the output register. No new beat is taken until that load, so a
// moving sample must finish before the next beat is accepted.
// One 33 x 33 multiplier and one CORDIC step are shared by all of this.
// The csr channel is always ready; registers are written by index and
// should be changed only while the block is idle.
// Reset loads the register defaults and zeroes the counts and the pose.
// A finished pose waits in the output register while rsp_ready is low; the
// block still takes new beats, and a later result holds in its last state
// until the output register is free.
module differential_drive_odometry_core
   import ddo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam logic signed [55:0] POSE_MAX = 56'sd140737488355327;
   localparam logic signed [55:0] POSE_MIN = -56'sd140737488355328;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   logic        enable_ff, enable_in;
   logic [19:0] ldc_ff, ldc_in, rdc_ff, rdc_in, lac_ff, lac_in, rac_ff, rac_in;
   logic [31:0] last_left_ff, last_left_in, last_right_ff, last_right_in;
   logic signed [47:0] x_ff, x_in, y_ff, y_in, h_ff, h_in;

   logic [31:0] nl_ff, nl_in, nr_ff, nr_in, dl_ff, dl_in, dr_ff, dr_in;
   logic signed [53:0] dist_ff, dist_in, ang_ff, ang_in;
   logic [47:0] hmag_ff, hmag_in;
   logic        hneg_ff, hneg_in;
   logic [24:0] rem_ff, rem_in;
   logic signed [34:0] z_ff, z_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        flip_ff, flip_in;
   logic [31:0] cmag_ff, cmag_in, smag_ff, smag_in;
   logic        cneg_ff, cneg_in, sneg_ff, sneg_in;
   logic [51:0] dmag_ff, dmag_in;
   logic        dneg_ff, dneg_in;
   logic [83:0] pacc_ff, pacc_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire, load_rsp, moving;

   function automatic logic [24:0] mod_step(input logic [24:0] r, input logic b);
      logic [25:0] t;
      t = {r, b};
      if (t >= {1'b0, FULL_TURN}) begin
         t = t - {1'b0, FULL_TURN};
      end
      return t[24:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
      logic signed [55:0] c;
      c = v;
      if (v > POSE_MAX) begin
         c = POSE_MAX;
      end else if (v < POSE_MIN) begin
         c = POSE_MIN;
      end
      return c[47:0];
   endfunction

   assign req_fire = req_valid && req_ready;
   assign moving   = (req_data.left_count != last_left_ff) ||
                     (req_data.right_count != last_right_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.op == OP_SAMPLE && enable_ff && moving) begin
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            if (cnt_ff == 5'd4) state_in = S_MOD;
         end
         S_MOD: begin
            if (cnt_ff == 5'(MOD_STEPS - 1)) state_in = S_WRAP;
         end
         S_WRAP:  state_in = S_FOLD1;
         S_FOLD1: state_in = S_FOLD2;
         S_FOLD2: state_in = S_CORDIC;
         S_CORDIC: begin
            if (cnt_ff == 5'(TRIG_ITERATIONS - 1)) state_in = S_TRIG_FIX;
         end
         S_TRIG_FIX: state_in = S_POSE;
         S_POSE: begin
            if (cnt_ff == 5'd6) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Handshakes and multiplier operands.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      csr_ready = 1'b1;
      load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_DELTA: begin
            case (cnt_ff)
               5'd0: begin
                  mul_a = {dl_ff[31], dl_ff};
                  mul_b = $signed({13'd0, ldc_ff});
               end
               5'd1: begin
                  mul_a = {dr_ff[31], dr_ff};
                  mul_b = $signed({13'd0, rdc_ff});
               end
               5'd2: begin
                  mul_a = {dr_ff[31], dr_ff};
                  mul_b = $signed({13'd0, rac_ff});
               end
               5'd3: begin
                  mul_a = {dl_ff[31], dl_ff};
                  mul_b = $signed({13'd0, lac_ff});
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         S_POSE: begin
            case (cnt_ff)
               5'd0: begin
                  mul_a = $signed({1'b0, dmag_ff[31:0]});
                  mul_b = $signed({1'b0, cmag_ff});
               end
               5'd1: begin
                  mul_a = $signed({13'd0, dmag_ff[51:32]});
                  mul_b = $signed({1'b0, cmag_ff});
               end
               5'd3: begin
                  mul_a = $signed({1'b0, dmag_ff[31:0]});
                  mul_b = $signed({1'b0, smag_ff});
               end
               5'd4: begin
                  mul_a = $signed({13'd0, dmag_ff[51:32]});
                  mul_b = $signed({1'b0, smag_ff});
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      logic [24:0]        r1;
      logic [24:0]        zmod;
      logic signed [33:0] xs, ys;
      logic signed [34:0] at;
      logic signed [33:0] cabs, sabs;
      logic signed [53:0] dabs, aabs;
      logic [48:0]        pmag;
      logic [53:0]        hinc;
      logic signed [55:0] sum;

      enable_in     = enable_ff;
      ldc_in        = ldc_ff;
      rdc_in        = rdc_ff;
      lac_in        = lac_ff;
      rac_in        = rac_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      h_in          = h_ff;
      nl_in         = nl_ff;
      nr_in         = nr_ff;
      dl_in         = dl_ff;
      dr_in         = dr_ff;
      dist_in       = dist_ff;
      ang_in        = ang_ff;
      hmag_in       = hmag_ff;
      hneg_in       = hneg_ff;
      rem_in        = rem_ff;
      z_in          = z_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      flip_in       = flip_ff;
      cmag_in       = cmag_ff;
      smag_in       = smag_ff;
      cneg_in       = cneg_ff;
      sneg_in       = sneg_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      pacc_in       = pacc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      cnt_in        = (state_in != state_ff) ? 5'd0 : cnt_ff + 5'd1;

      r1   = mod_step(rem_ff, hmag_ff[47]);
      zmod = (hneg_ff && rem_ff != '0) ? FULL_TURN - rem_ff : rem_ff;
      xs   = cx_ff >>> cnt_ff;
      ys   = cy_ff >>> cnt_ff;
      at   = $signed({5'd0, ATAN_Q24[cnt_ff]});
      cabs = cx_ff[33] ? -cx_ff : cx_ff;
      sabs = cy_ff[33] ? -cy_ff : cy_ff;
      dabs = dist_ff[53] ? -dist_ff : dist_ff;
      aabs = ang_ff[53] ? -ang_ff : ang_ff;
      pmag = 49'(pacc_ff >> MUL_SHIFT);
      hinc = 54'(aabs) >> (COEFF_FRAC_BITS - POSE_FRAC_BITS);
      sum  = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ENABLE:      enable_in = csr_data[0];
            REG_LEFT_DIST:   ldc_in    = csr_data;
            REG_RIGHT_DIST:  rdc_in    = csr_data;
            REG_LEFT_ANGLE:  lac_in    = csr_data;
            REG_RIGHT_ANGLE: rac_in    = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_CLEAR) begin
                  last_left_in  = '0;
                  last_right_in = '0;
                  x_in          = '0;
                  y_in          = '0;
                  h_in          = '0;
               end else begin
                  nl_in = req_data.left_count;
                  nr_in = req_data.right_count;
                  dl_in = req_data.left_count - last_left_ff;
                  dr_in = req_data.right_count - last_right_ff;
               end
            end
         end
         S_DELTA: begin
            case (cnt_ff)
               5'd1: dist_in = 54'(mul_p_ff);
               5'd2: dist_in = dist_ff + 54'(mul_p_ff);
               5'd3: ang_in  = 54'(mul_p_ff);
               5'd4: begin
                  ang_in  = ang_ff - 54'(mul_p_ff);
                  hmag_in = h_ff[47] ? 48'(-h_ff) : 48'(h_ff);
                  hneg_in = h_ff[47];
                  rem_in  = '0;
               end
               default: ;
            endcase
         end
         S_MOD: begin
            // Two restoring steps a cycle, most significant bits first.
            rem_in  = mod_step(r1, hmag_ff[46]);
            hmag_in = {hmag_ff[45:0], 2'b00};
         end
         S_WRAP: begin
            z_in = $signed(35'(zmod)) <<< (ANG_FRAC - POSE_FRAC_BITS);
         end
         S_FOLD1: begin
            if (z_ff > HALF_TURN) z_in = z_ff - (HALF_TURN <<< 1);
         end
         S_FOLD2: begin
            flip_in = 1'b0;
            if (z_ff > QUARTER_TURN) begin
               z_in    = z_ff - HALF_TURN;
               flip_in = 1'b1;
            end else if (z_ff < -QUARTER_TURN) begin
               z_in    = z_ff + HALF_TURN;
               flip_in = 1'b1;
            end
            cx_in = GAIN_Q30;
            cy_in = '0;
         end
         S_CORDIC: begin
            if (!z_ff[34]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + at;
            end
         end
         S_TRIG_FIX: begin
            cmag_in = cabs[31:0];
            smag_in = sabs[31:0];
            cneg_in = cx_ff[33] ^ flip_ff;
            sneg_in = cy_ff[33] ^ flip_ff;
            dmag_in = dabs[51:0];
            dneg_in = dist_ff[53];
         end
         S_POSE: begin
            case (cnt_ff)
               5'd1, 5'd4: pacc_in = 84'(mul_p_ff[63:0]);
               5'd2, 5'd5: pacc_in = pacc_ff + {mul_p_ff[51:0], 32'd0};
               5'd3: begin
                  sum  = 56'(x_ff) + ((dneg_ff ^ cneg_ff) ? -$signed(56'(pmag))
                                                          : $signed(56'(pmag)));
                  x_in = sat48(sum);
               end
               5'd6: begin
                  sum  = 56'(y_ff) + ((dneg_ff ^ sneg_ff) ? -$signed(56'(pmag))
                                                          : $signed(56'(pmag)));
                  y_in = sat48(sum);
                  sum  = 56'(h_ff) + (ang_ff[53] ? -$signed(56'(hinc))
                                                 : $signed(56'(hinc)));
                  h_in = sat48(sum);
                  last_left_in  = nl_ff;
                  last_right_in = nr_ff;
               end
               default: ;
            endcase
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.pos_x   = x_ff;
               rsp_data_in.pos_y   = y_ff;
               rsp_data_in.heading = h_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff    <= mul_a * mul_b;
      nl_ff       <= nl_in;
      nr_ff       <= nr_in;
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      dist_ff     <= dist_in;
      ang_ff      <= ang_in;
      hmag_ff     <= hmag_in;
      hneg_ff     <= hneg_in;
      rem_ff      <= rem_in;
      z_ff        <= z_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      flip_ff     <= flip_in;
      cmag_ff     <= cmag_in;
      smag_ff     <= smag_in;
      cneg_ff     <= cneg_in;
      sneg_ff     <= sneg_in;
      dmag_ff     <= dmag_in;
      dneg_ff     <= dneg_in;
      pacc_ff     <= pacc_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         enable_ff     <= 1'b0;
         ldc_ff        <= 20'd74659;
         rdc_ff        <= 20'd74659;
         lac_ff        <= 20'd84253;
         rac_ff        <= 20'd84253;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         h_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         enable_ff     <= enable_in;
         ldc_ff        <= ldc_in;
         rdc_ff        <= rdc_in;
         lac_ff        <= lac_in;
         rac_ff        <= rac_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         h_ff          <= h_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_zeroes_pose: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.op == OP_CLEAR |=> x_ff == '0 && y_ff == '0 && h_ff == '0)
      else $error("clear beat did not zero the pose");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOD |-> rem_ff < FULL_TURN)
      else $error("heading remainder out of range");

   a_wrapped_angle_positive: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FOLD1 |-> !z_ff[34])
      else $error("reduced heading is negative");

   a_done_after_pose: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && $past(state_ff) != S_DONE |-> $past(state_ff) == S_POSE)
      else $error("result stage entered out of order");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ddo_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [19:0] csr_data = '0;

   differential_drive_odometry_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   localparam longint POSE_LIMIT = 64'sd1 << 62;

   // Mirror of the block's registers and dead-reckoning state.
   logic        odo_enable = 0;
   logic [19:0] left_dist = 20'd74659;
   logic [19:0] right_dist = 20'd74659;
   logic [19:0] left_angle = 20'd84253;
   logic [19:0] right_angle = 20'd84253;
   logic [31:0] last_left = '0;
   logic [31:0] last_right = '0;
   longint      x_pos = 0;
   longint      y_pos = 0;
   longint      head = 0;

   req_type     pending_samples[$];
   rsp_type     expected_poses[$];
   int          mismatches = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   logic [31:0] gen_left = '0;
   logic [31:0] gen_right = '0;

   function automatic longint clamp_mag(logic [127:0] m, bit neg);
      longint v;
      v = (m > 128'(POSE_LIMIT)) ? POSE_LIMIT : longint'(m[63:0]);
      return neg ? -v : v;
   endfunction

   // Product scaled down by 2^sh, truncated toward zero.
   function automatic longint scaled_product(longint a, longint c, int sh);
      logic [63:0]  ua, uc;
      logic [127:0] p;
      ua = (a < 0) ? -a : a;
      uc = (c < 0) ? -c : c;
      p = {64'd0, ua} * {64'd0, uc};
      return clamp_mag(p >> sh, (a < 0) != (c < 0));
   endfunction

   function automatic longint sat_pose(longint v);
      longint hi;
      hi = (64'sd1 <<< 47) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Cosine and sine of a heading in degrees, Q2.30, by rotation CORDIC.
   function automatic void heading_trig(input longint h, output longint cs, output longint sn);
      longint full, half, quarter, r, z, x, y, nx, ny;
      bit     flip;
      full = 64'sd360 <<< POSE_FRAC_BITS;
      half = 64'sd180 <<< ANG_FRAC;
      quarter = 64'sd90 <<< ANG_FRAC;
      flip = 0;
      x = GAIN_Q30;
      y = 0;
      r = h % full;
      if (r < 0) r += full;
      z = r <<< (ANG_FRAC - POSE_FRAC_BITS);
      if (z > half) z -= 2 * half;
      if (z > quarter) begin
         z -= half;
         flip = 1;
      end else if (z < -quarter) begin
         z += half;
         flip = 1;
      end
      for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_Q24[i]);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_Q24[i]);
         end
         x = nx;
         y = ny;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   task automatic advance_pose(req_type it);
      logic signed [31:0] d32;
      longint  dl, dr, dist_mm, ang, cs, sn, turn;
      rsp_type pose;
      if (it.op == OP_CLEAR) begin
         last_left = '0;
         last_right = '0;
         x_pos = 0;
         y_pos = 0;
         head = 0;
         return;
      end
      if (!odo_enable) return;
      if (it.left_count == last_left && it.right_count == last_right) return;
      d32 = it.left_count - last_left;
      dl = d32;
      d32 = it.right_count - last_right;
      dr = d32;
      dist_mm = dl * longint'(left_dist) + dr * longint'(right_dist);
      ang = dr * longint'(right_angle) - dl * longint'(left_angle);
      heading_trig(head, cs, sn);
      x_pos = sat_pose(x_pos + scaled_product(dist_mm, cs, MUL_SHIFT));
      y_pos = sat_pose(y_pos + scaled_product(dist_mm, sn, MUL_SHIFT));
      turn = clamp_mag(128'((ang < 0) ? -ang : ang) >> (COEFF_FRAC_BITS - POSE_FRAC_BITS),
                       ang < 0);
      head = sat_pose(head + turn);
      last_left = it.left_count;
      last_right = it.right_count;
      pose.pos_x = x_pos[47:0];
      pose.pos_y = y_pos[47:0];
      pose.heading = head[47:0];
      expected_poses.push_back(pose);
   endtask

   // Sender: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) advance_pose(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pending_samples.size() == 0) begin
               req_valid <= 0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_data <= pending_samples.pop_front();
               req_valid <= 1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
   end

   // Receiver: stall pattern switches between always ready, coin flip and mostly stalled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pose beat %h", rsp_data);
            end else if (expected_poses[0] != rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pose mismatch: x %h/%h y %h/%h heading %h/%h (expected/actual)",
                           expected_poses[0].pos_x, rsp_data.pos_x,
                           expected_poses[0].pos_y, rsp_data.pos_y,
                           expected_poses[0].heading, rsp_data.heading);
               void'(expected_poses.pop_front());
            end else begin
               void'(expected_poses.pop_front());
            end
         end
         if ($urandom_range(0, 149) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [19:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ENABLE:      odo_enable = val[0];
         REG_LEFT_DIST:   left_dist = val;
         REG_RIGHT_DIST:  right_dist = val;
         REG_LEFT_ANGLE:  left_angle = val;
         REG_RIGHT_ANGLE: right_angle = val;
         default: ;
      endcase
   endtask

   task automatic write_all(logic en, logic [19:0] ld, logic [19:0] rd,
                            logic [19:0] la, logic [19:0] ra);
      write_reg(REG_ENABLE, {19'd0, en});
      write_reg(REG_LEFT_DIST, ld);
      write_reg(REG_RIGHT_DIST, rd);
      write_reg(REG_LEFT_ANGLE, la);
      write_reg(REG_RIGHT_ANGLE, ra);
      csr_valid <= 0;
   endtask

   // Waits for the sender to drain and every pose to come back, then lets
   // a moving sample that produced nothing settle.
   task automatic drain;
      @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic push_sample(logic op, logic [31:0] l, logic [31:0] r);
      req_type it;
      it.op = op;
      it.left_count = l;
      it.right_count = r;
      pending_samples.push_back(it);
      if (op == OP_CLEAR) begin
         gen_left = '0;
         gen_right = '0;
      end else begin
         gen_left = l;
         gen_right = r;
      end
   endtask

   // Mostly small wheel moves from the last counts, with larger moves, clears, repeats and wild jumps.
   task automatic push_random(int n);
      int sel;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3)
            push_sample(OP_CLEAR, $urandom, $urandom);
         else if (sel < 8)
            push_sample(OP_SAMPLE, gen_left, gen_right);
         else if (sel < 16)
            push_sample(OP_SAMPLE, $urandom, $urandom);
         else if (sel < 24)
            push_sample(OP_SAMPLE, gen_left + $urandom_range(0, 200000) - 100000,
                        gen_right + $urandom_range(0, 200000) - 100000);
         else
            push_sample(OP_SAMPLE, gen_left + $urandom_range(0, 400) - 200,
                        gen_right + $urandom_range(0, 400) - 200);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_all(1, 20'd74659, 20'd74659, 20'd84253, 20'd84253);
      push_sample(OP_CLEAR, 0, 0);
      push_sample(OP_SAMPLE, 0, 0);
      push_sample(OP_SAMPLE, 100, 100);
      push_sample(OP_SAMPLE, 100, 100);
      push_sample(OP_SAMPLE, 200, 50);
      push_sample(OP_SAMPLE, 32'h7fffffff, 32'h7fffffff);
      push_sample(OP_SAMPLE, 32'h80000000, 32'h80000000);
      push_sample(OP_SAMPLE, 32'hffffffff, 32'h00000000);
      push_sample(OP_SAMPLE, 32'h00000000, 32'h7fffffff);
      push_sample(OP_CLEAR, 32'hffffffff, 32'hffffffff);
      push_sample(OP_SAMPLE, 5, -5);
      push_sample(OP_SAMPLE, -300, 900);
      push_sample(OP_SAMPLE, 32'h80000000, 32'h7fffffff);
      push_sample(OP_SAMPLE, 32'h7fffffff, 32'h80000000);
      push_sample(OP_SAMPLE, 32'hffffffff, 32'hffffffff);
      push_sample(OP_SAMPLE, 1, 1);
      drain();

      // A stray index must leave the registers untouched.
      write_reg(3'd7, 20'hfffff);
      write_all(1, 20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff);
      push_random(130);
      drain();

      write_all(1, 20'd0, 20'd0, 20'd0, 20'd0);
      push_random(60);
      drain();

      write_all(0, 20'd1000, 20'd2000, 20'd3000, 20'd4000);
      push_random(40);
      drain();

      repeat (4) begin
         write_all(1, 20'($urandom_range(0, 20'hfffff)), 20'($urandom_range(0, 20'hfffff)),
                   20'($urandom_range(0, 200000)), 20'($urandom_range(0, 200000)));
         push_random(130);
         drain();
      end

      if (mismatches == 0 && expected_poses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
